// ----- sv/fsbc_pkg.sv -----
// fsbc_pkg: shared types, constants and helpers of the frame scope byte counter.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fsbc_pkg;

  localparam int PREFIX_ENTRIES_DEF = 64;
  localparam int IFACE_COUNT_DEF    = 16;

  localparam logic [15:0] ET_VLAN = 16'h8100;
  localparam logic [15:0] ET_QINQ = 16'h88A8;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  localparam logic SCOPE_INT = 1'b0;
  localparam logic SCOPE_EXT = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  frame_byte;
    logic        end_of_frame;
    logic [3:0]  iface;
    logic        direction;
    logic [5:0]  entry_index;
    logic        entry_enable;
    logic        entry_is_v6;
    logic [7:0]  prefix_len;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } in_item_t;

  typedef struct packed {
    logic        scope;
    logic [3:0]  out_iface;
    logic        out_direction;
    logic [15:0] frame_bytes;
    logic [63:0] byte_total;
  } out_item_t;

  typedef struct packed {
    logic         is_v6;
    logic [7:0]   bits;
    logic [127:0] key;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan_en;
    logic clr_en;
    logic cnt_rd;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic clr_last;
    logic out_busy;
  } ctl_sts_t;

  typedef struct packed {
    logic [5:0] start;
    logic [4:0] len;
  } win_t;

  function automatic win_t addr_window(input logic [15:0] et, input logic tag,
                                       input logic dir);
    win_t       w;
    logic [5:0] base;
    base = tag ? 6'd18 : 6'd14;
    w.start = '0;
    w.len   = '0;
    if (et == ET_IPV4) begin
      w.start = base + (dir ? 6'd16 : 6'd12);
      w.len   = 5'd4;
    end else if (et == ET_IPV6) begin
      w.start = base + (dir ? 6'd24 : 6'd8);
      w.len   = 5'd16;
    end
    return w;
  endfunction

endpackage

// ----- sv/fsbc_if.sv -----
// fsbc_in_if and fsbc_out_if: valid/ready request and result channels of the counter.
// Depend on nothing; payload widths are fixed.
`timescale 1ns / 1ps

interface fsbc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  frame_byte;
  logic        end_of_frame;
  logic [3:0]  iface;
  logic        direction;
  logic [5:0]  entry_index;
  logic        entry_enable;
  logic        entry_is_v6;
  logic [7:0]  prefix_len;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  modport source (output valid, cmd, frame_byte, end_of_frame, iface, direction,
                  entry_index, entry_enable, entry_is_v6, prefix_len, addr_high,
                  addr_low, input ready);
  modport sink (input valid, cmd, frame_byte, end_of_frame, iface, direction,
                entry_index, entry_enable, entry_is_v6, prefix_len, addr_high,
                addr_low, output ready);
endinterface

interface fsbc_out_if;
  logic        valid;
  logic        ready;
  logic        scope;
  logic [3:0]  out_iface;
  logic        out_direction;
  logic [15:0] frame_bytes;
  logic [63:0] byte_total;
  modport source (output valid, scope, out_iface, out_direction, frame_bytes,
                  byte_total, input ready);
  modport sink (input valid, scope, out_iface, out_direction, frame_bytes,
                byte_total, output ready);
endinterface

// ----- sv/fsbc_ctrl.sv -----
// fsbc_ctrl: sequencer for counter clearing, prefix scan and counter update.
// Depends on fsbc_pkg; drives the datapath by command and reads its status.
`timescale 1ns / 1ps

module fsbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_byte,
  output logic              in_ready,
  input  logic              out_ready,
  input  fsbc_pkg::ctl_sts_t sts,
  output fsbc_pkg::ctl_cmd_t cmd
);
  import fsbc_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_CREAD  = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last_byte) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_CREAD;
      S_CREAD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_busy || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// ----- sv/fsbc_dp.sv -----
// fsbc_dp: frame parser registers, prefix memory with scan compare, counter memory
// and output register. Depends on fsbc_pkg; controlled by fsbc_ctrl.
`timescale 1ns / 1ps

module fsbc_dp #(
  parameter int PREFIX_ENTRIES = fsbc_pkg::PREFIX_ENTRIES_DEF,
  parameter int IFACE_COUNT    = fsbc_pkg::IFACE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fsbc_pkg::in_item_t  item,
  input  fsbc_pkg::ctl_cmd_t  cmd,
  output fsbc_pkg::ctl_sts_t  sts,
  input  logic                out_ready,
  output logic                out_valid,
  output fsbc_pkg::out_item_t out_item
);
  import fsbc_pkg::*;

  localparam int PE_AW     = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;
  localparam int CNT_DEPTH = IFACE_COUNT * 4;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);

  // frame state
  logic [15:0]  off_r, off_nxt;
  logic [15:0]  et_r, et_nxt;
  logic         tag_r, tag_nxt;
  logic [63:0]  capu_r, capu_nxt, capl_r, capl_nxt;
  logic [3:0]   iface_r, iface_nxt;
  logic         dir_r, dir_nxt;
  win_t         win_n, win_c;
  logic [15:0]  k;
  logic         in_win;
  logic         frame_acc, table_acc;

  assign frame_acc = cmd.accept && (item.cmd == CMD_FRAME);
  assign table_acc = cmd.accept && (item.cmd == CMD_TABLE);

  always_comb begin
    off_nxt   = off_r;
    et_nxt    = et_r;
    tag_nxt   = tag_r;
    capu_nxt  = capu_r;
    capl_nxt  = capl_r;
    iface_nxt = iface_r;
    dir_nxt   = dir_r;
    if (off_r == 16'd0) begin
      iface_nxt = item.iface;
      dir_nxt   = item.direction;
    end
    if (off_r == 16'd12 || (tag_r && off_r == 16'd16))
      et_nxt = {item.frame_byte, et_r[7:0]};
    else if (off_r == 16'd13 || (tag_r && off_r == 16'd17))
      et_nxt = {et_r[15:8], item.frame_byte};
    if (off_r == 16'd13 && !tag_r && (et_nxt == ET_VLAN || et_nxt == ET_QINQ))
      tag_nxt = 1'b1;
    win_n  = addr_window(et_nxt, tag_nxt, dir_r);
    k      = off_r - 16'(win_n.start);
    in_win = (win_n.len != 5'd0) && (off_r >= 16'(win_n.start))
             && (off_r < 16'(win_n.start) + 16'(win_n.len));
    if (in_win) begin
      if (win_n.len == 5'd4)
        capl_nxt = {32'd0, capl_r[23:0], item.frame_byte};
      else if (k < 16'd8)
        capu_nxt = {capu_r[55:0], item.frame_byte};
      else
        capl_nxt = {capl_r[55:0], item.frame_byte};
    end
    if (off_r != 16'hFFFF) off_nxt = off_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.commit) begin
      off_r  <= '0;
      et_r   <= '0;
      tag_r  <= 1'b0;
      capu_r <= '0;
      capl_r <= '0;
    end else if (frame_acc) begin
      off_r  <= off_nxt;
      et_r   <= et_nxt;
      tag_r  <= tag_nxt;
      capu_r <= capu_nxt;
      capl_r <= capl_nxt;
    end
    if (!rst_n) begin
      iface_r <= '0;
      dir_r   <= 1'b0;
    end else if (frame_acc) begin
      iface_r <= iface_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // prefix table
  entry_t                    pmem [PREFIX_ENTRIES];
  logic [PREFIX_ENTRIES-1:0] pvalid_r;
  logic [8:0]                widx;
  logic [7:0]                nmax, nclamp;
  entry_t                    went;
  logic [PE_AW-1:0]          scan_idx_r;
  entry_t                    pq_r;
  logic                      pq_valid_r, stg_r, hit_r;
  logic                      probe_v6;
  logic [127:0]              probe, pmask;
  logic                      match;

  assign widx   = 9'(item.entry_index);
  assign nmax   = item.entry_is_v6 ? 8'd128 : 8'd32;
  assign nclamp = (item.prefix_len > nmax) ? nmax : item.prefix_len;
  assign went.is_v6 = item.entry_is_v6;
  assign went.bits  = nclamp;
  assign went.key   = item.entry_is_v6 ? {item.addr_high, item.addr_low}
                                       : {item.addr_low[31:0], 96'd0};

  always_ff @(posedge clk) begin
    if (table_acc && widx < 9'(PREFIX_ENTRIES))
      pmem[widx[PE_AW-1:0]] <= went;
    if (cmd.scan_en) pq_r <= pmem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pvalid_r <= '0;
    else if (table_acc && widx < 9'(PREFIX_ENTRIES))
      pvalid_r[widx[PE_AW-1:0]] <= item.entry_enable;
  end

  assign sts.scan_last = (scan_idx_r == PE_AW'(PREFIX_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      stg_r      <= 1'b0;
      pq_valid_r <= 1'b0;
    end else begin
      stg_r <= cmd.scan_en;
      if (cmd.scan_en) begin
        pq_valid_r <= pvalid_r[scan_idx_r];
        scan_idx_r <= sts.scan_last ? '0 : scan_idx_r + 1'b1;
      end
    end
  end

  assign probe_v6 = (et_r == ET_IPV6);
  assign probe    = probe_v6 ? {capu_r, capl_r} : {capl_r[31:0], 96'd0};
  assign pmask    = ~128'd0 << (8'd128 - pq_r.bits);
  assign match    = stg_r && pq_valid_r && (pq_r.is_v6 == probe_v6)
                    && (((pq_r.key ^ probe) & pmask) == 128'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) hit_r <= 1'b0;
    else if (frame_acc && item.end_of_frame) hit_r <= 1'b0;
    else if (match) hit_r <= 1'b1;
  end

  // classification
  logic scope_c;
  always_comb begin
    win_c = addr_window(et_r, tag_r, dir_r);
    priority if (off_r < 16'd14)                 scope_c = SCOPE_EXT;
    else if (tag_r && off_r < 16'd18)            scope_c = SCOPE_EXT;
    else if (et_r == ET_ARP)                     scope_c = SCOPE_INT;
    else if (win_c.len == 5'd0
             || off_r < 16'(win_c.start) + 16'(win_c.len)) scope_c = SCOPE_EXT;
    else                                         scope_c = hit_r ? SCOPE_INT : SCOPE_EXT;
  end

  // byte counters
  logic [63:0]       cmem [CNT_DEPTH];
  logic [63:0]       cq_r, sum;
  logic [7:0]        row;
  logic [CNT_AW-1:0] cidx, clr_idx_r;

  always_comb begin
    row = '0;
    for (int v = 0; v < 16; v++)
      if (iface_r == 4'(v)) row = 8'(v % IFACE_COUNT);
  end

  assign cidx = CNT_AW'({row, dir_r, scope_c});
  assign sum  = cq_r + 64'(off_r);
  assign sts.clr_last = (clr_idx_r == CNT_AW'(CNT_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.clr_en)      cmem[clr_idx_r] <= '0;
    else if (cmd.commit) cmem[cidx] <= sum;
    if (cmd.cnt_rd) cq_r <= cmem[cidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_idx_r <= '0;
    else if (cmd.clr_en) clr_idx_r <= clr_idx_r + 1'b1;
  end

  // result register
  logic      out_valid_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.commit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
    if (cmd.commit) begin
      out_r.scope         <= scope_c;
      out_r.out_iface     <= iface_r;
      out_r.out_direction <= dir_r;
      out_r.frame_bytes   <= off_r;
      out_r.byte_total    <= sum;
    end
  end

  assign sts.out_busy = out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_item     = out_r;

endmodule

// ----- sv/frame_scope_byte_counter.sv -----
// Frame scope byte counter. Table writes and non-final frame bytes are taken while idle.
// A final frame byte starts a result pass: the prefix memory is scanned one entry a
// cycle, then the counter memory is read, added and written, and the result registered;
// the write waits while an earlier result is held and not taken. After reset a clearing
// pass zeroes all IFACE_COUNT * 4 counter words, during which no request is taken.
// Reset is synchronous, active low. Depends on fsbc_pkg, fsbc_if, fsbc_ctrl and fsbc_dp.
`timescale 1ns / 1ps

module frame_scope_byte_counter #(
  parameter int PREFIX_ENTRIES = fsbc_pkg::PREFIX_ENTRIES_DEF,
  parameter int IFACE_COUNT    = fsbc_pkg::IFACE_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fsbc_in_if.sink    in_s,
  fsbc_out_if.source out_m
);
  import fsbc_pkg::*;

  in_item_t  item;
  out_item_t oitem;
  ctl_cmd_t  cmd;
  ctl_sts_t  sts;
  logic      last_byte;

  assign item = '{cmd: in_s.cmd, frame_byte: in_s.frame_byte,
                  end_of_frame: in_s.end_of_frame, iface: in_s.iface,
                  direction: in_s.direction, entry_index: in_s.entry_index,
                  entry_enable: in_s.entry_enable, entry_is_v6: in_s.entry_is_v6,
                  prefix_len: in_s.prefix_len, addr_high: in_s.addr_high,
                  addr_low: in_s.addr_low};
  assign last_byte = (in_s.cmd == CMD_FRAME) && in_s.end_of_frame;

  fsbc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_s.valid),
    .in_last_byte (last_byte),
    .in_ready     (in_s.ready),
    .out_ready    (out_m.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  fsbc_dp #(
    .PREFIX_ENTRIES (PREFIX_ENTRIES),
    .IFACE_COUNT    (IFACE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_m.ready),
    .out_valid (out_m.valid),
    .out_item  (oitem)
  );

  assign out_m.scope         = oitem.scope;
  assign out_m.out_iface     = oitem.out_iface;
  assign out_m.out_direction = oitem.out_direction;
  assign out_m.frame_bytes   = oitem.frame_bytes;
  assign out_m.byte_total    = oitem.byte_total;

endmodule

// ----- sv/fsbc_chk.sv -----
// fsbc_chk: port-level checks of the frame scope byte counter, bound to the top level.
// Depends on fsbc_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps

module fsbc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic        in_eof,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_frame_bytes
);
  import fsbc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_bytes))
    else $error("result dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_bytes != 16'd0)
    else $error("result with zero frame length");

  a_scan_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_FRAME && in_eof |=> !in_ready)
    else $error("request taken during frame end processing");

endmodule

bind frame_scope_byte_counter fsbc_chk u_fsbc_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_s.valid),
  .in_ready        (in_s.ready),
  .in_cmd          (in_s.cmd),
  .in_eof          (in_s.end_of_frame),
  .out_valid       (out_m.valid),
  .out_ready       (out_m.ready),
  .out_frame_bytes (out_m.frame_bytes)
);

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench of frame_scope_byte_counter with a byte-level predictor.
// Depends on fsbc_pkg, fsbc_in_if, fsbc_out_if and the frame_scope_byte_counter top.
`timescale 1ns / 1ps

module tb_top;
  import fsbc_pkg::*;

  localparam int CYCLE_LIMIT = 40000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fsbc_in_if  in_if ();
  fsbc_out_if out_if ();

  frame_scope_byte_counter dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if.sink),
    .out_m (out_if.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic        tbl_valid [64];
  logic        tbl_v6    [64];
  logic [7:0]  tbl_bits  [64];
  logic [63:0] tbl_hi    [64];
  logic [63:0] tbl_lo    [64];
  logic [63:0] scope_bytes [64];
  int unsigned cur_offs;
  logic [15:0] cur_etype;
  logic        cur_tagged;
  logic [63:0] cur_hi, cur_lo;
  logic [3:0]  cur_iface;
  logic        cur_dir;

  out_item_t   expected_counts [$];
  int          errors = 0;
  int          cycles = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_cycles = 0;
  logic [127:0] addr_pool [4];

  initial begin
    for (int i = 0; i < 64; i++) begin
      tbl_valid[i] = 1'b0;
      scope_bytes[i] = '0;
    end
    cur_offs = 0; cur_etype = '0; cur_tagged = 1'b0;
    cur_hi = '0; cur_lo = '0; cur_iface = '0; cur_dir = 1'b0;
    in_if.valid = 1'b0; in_if.cmd = CMD_FRAME; in_if.frame_byte = '0;
    in_if.end_of_frame = 1'b0; in_if.iface = '0; in_if.direction = 1'b0;
    in_if.entry_index = '0; in_if.entry_enable = 1'b0; in_if.entry_is_v6 = 1'b0;
    in_if.prefix_len = '0; in_if.addr_high = '0; in_if.addr_low = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic [63:0] lead_mask(int n);
    if (n <= 0) return '0;
    if (n >= 64) return '1;
    return ~64'd0 << (64 - n);
  endfunction

  function automatic void addr_span(output int s, output int l);
    int base;
    base = cur_tagged ? 18 : 14;
    s = 0; l = 0;
    if (cur_etype == ET_IPV4) begin
      s = base + (cur_dir ? 16 : 12); l = 4;
    end else if (cur_etype == ET_IPV6) begin
      s = base + (cur_dir ? 24 : 8); l = 16;
    end
  endfunction

  function automatic logic prefix_hit(logic v6);
    logic [63:0] m;
    for (int i = 0; i < 64; i++) begin
      if (!tbl_valid[i] || tbl_v6[i] != v6) continue;
      if (!v6) begin
        m = lead_mask(tbl_bits[i]) >> 32;
        if (((tbl_lo[i] ^ cur_lo) & m) == 0) return 1'b1;
      end else begin
        if (((tbl_hi[i] ^ cur_hi) & lead_mask(tbl_bits[i])) == 0 &&
            ((tbl_lo[i] ^ cur_lo) & lead_mask(int'(tbl_bits[i]) - 64)) == 0)
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic frame_scope(int unsigned total);
    int s, l;
    if (total < 14) return SCOPE_EXT;
    if (cur_tagged && total < 18) return SCOPE_EXT;
    if (cur_etype == ET_ARP) return SCOPE_INT;
    addr_span(s, l);
    if (l == 0 || total < s + l) return SCOPE_EXT;
    return prefix_hit(cur_etype == ET_IPV6) ? SCOPE_INT : SCOPE_EXT;
  endfunction

  function automatic void predict_counts(in_item_t it);
    int s, l, pos, row, n;
    out_item_t r;
    if (it.cmd == CMD_TABLE) begin
      n = it.prefix_len;
      if (n > (it.entry_is_v6 ? 128 : 32)) n = it.entry_is_v6 ? 128 : 32;
      tbl_valid[it.entry_index] = it.entry_enable;
      tbl_v6[it.entry_index]    = it.entry_is_v6;
      tbl_bits[it.entry_index]  = n[7:0];
      tbl_hi[it.entry_index]    = it.entry_is_v6 ? it.addr_high : 64'd0;
      tbl_lo[it.entry_index]    = it.entry_is_v6 ? it.addr_low : {32'd0, it.addr_low[31:0]};
      return;
    end
    pos = cur_offs;
    if (pos == 0) begin
      cur_iface = it.iface; cur_dir = it.direction;
    end
    if (pos == 12 || (cur_tagged && pos == 16)) cur_etype[15:8] = it.frame_byte;
    else if (pos == 13 || (cur_tagged && pos == 17)) cur_etype[7:0] = it.frame_byte;
    if (pos == 13 && !cur_tagged && (cur_etype == ET_VLAN || cur_etype == ET_QINQ))
      cur_tagged = 1'b1;
    addr_span(s, l);
    if (l != 0 && pos >= s && pos < s + l) begin
      if (l == 4) cur_lo = {32'd0, cur_lo[23:0], it.frame_byte};
      else if (pos - s < 8) cur_hi = {cur_hi[55:0], it.frame_byte};
      else cur_lo = {cur_lo[55:0], it.frame_byte};
    end
    if (cur_offs < 65535) cur_offs++;
    if (!it.end_of_frame) return;
    r.scope = frame_scope(cur_offs);
    row = (int'(cur_iface) * 2 + cur_dir) * 2 + r.scope;
    scope_bytes[row] = scope_bytes[row] + cur_offs;
    r.out_iface = cur_iface;
    r.out_direction = cur_dir;
    r.frame_bytes = cur_offs[15:0];
    r.byte_total = scope_bytes[row];
    expected_counts.push_back(r);
    cur_offs = 0; cur_etype = '0; cur_tagged = 1'b0; cur_hi = '0; cur_lo = '0;
  endfunction

  task automatic send_request(in_item_t it);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= it.cmd; in_if.frame_byte <= it.frame_byte;
    in_if.end_of_frame <= it.end_of_frame; in_if.iface <= it.iface;
    in_if.direction <= it.direction; in_if.entry_index <= it.entry_index;
    in_if.entry_enable <= it.entry_enable; in_if.entry_is_v6 <= it.entry_is_v6;
    in_if.prefix_len <= it.prefix_len; in_if.addr_high <= it.addr_high;
    in_if.addr_low <= it.addr_low;
    do @(posedge clk); while (!in_if.ready);
    predict_counts(it);
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  task automatic write_prefix(int slot, logic en, logic v6, int len, logic [127:0] a);
    in_item_t it;
    it = noise_item();
    it.cmd = CMD_TABLE; it.entry_index = slot[5:0]; it.entry_enable = en;
    it.entry_is_v6 = v6; it.prefix_len = len[7:0];
    it.addr_high = a[127:64]; it.addr_low = a[63:0];
    send_request(it);
  endtask

  // tags: 0 none, 1 single 802.1Q, 2 single 802.1ad, 3 two tags
  task automatic send_frame(logic [3:0] ifc, logic dir, logic [15:0] et, int tags,
                            logic [127:0] a, int len, int mid_write = -1);
    logic [7:0] fb [];
    int p, l3, n;
    in_item_t it;
    n = (len > 100) ? len : 100;
    fb = new[n];
    for (int i = 0; i < n; i++) fb[i] = $urandom;
    p = 12;
    for (int t = 0; t < ((tags == 3) ? 2 : (tags > 0 ? 1 : 0)); t++) begin
      {fb[p], fb[p+1]} = (tags == 1 || t == 1) ? ET_VLAN : ET_QINQ;
      p += 4;
    end
    {fb[p], fb[p+1]} = et;
    l3 = p + 2;
    if (et == ET_IPV4) begin
      for (int k = 0; k < 4; k++) fb[l3 + (dir ? 16 : 12) + k] = a[31 - 8*k -: 8];
    end else if (et == ET_IPV6) begin
      for (int k = 0; k < 16; k++) fb[l3 + (dir ? 24 : 8) + k] = a[127 - 8*k -: 8];
    end
    for (int i = 0; i < len; i++) begin
      if (i == mid_write) write_prefix(5, 1'b1, 1'b0, 0, '0);
      it = noise_item();
      it.cmd = CMD_FRAME; it.frame_byte = fb[i]; it.end_of_frame = (i == len - 1);
      it.iface = ifc; it.direction = dir;
      send_request(it);
    end
  endtask

  function automatic int hdr_len(logic [15:0] et, int tags);
    return 14 + 4 * ((tags == 3) ? 2 : (tags > 0 ? 1 : 0)) + (et == ET_IPV6 ? 40 : 20);
  endfunction

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("unexpected result", out_if.byte_total, 0);
      end else begin
        want = expected_counts.pop_front();
        if (out_if.scope !== want.scope)
          report_mismatch("scope", out_if.scope, want.scope);
        if (out_if.out_iface !== want.out_iface)
          report_mismatch("out_iface", out_if.out_iface, want.out_iface);
        if (out_if.out_direction !== want.out_direction)
          report_mismatch("out_direction", out_if.out_direction, want.out_direction);
        if (out_if.frame_bytes !== want.frame_bytes)
          report_mismatch("frame_bytes", out_if.frame_bytes, want.frame_bytes);
        if (out_if.byte_total !== want.byte_total)
          report_mismatch("byte_total", out_if.byte_total, want.byte_total);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL frame_scope_byte_counter");
      $finish;
    end
  end

  task automatic test_table_extremes();
    write_prefix(0, 1'b1, 1'b0, 32, addr_pool[0]);
    write_prefix(63, 1'b1, 1'b1, 128, addr_pool[1]);
    write_prefix(1, 1'b1, 1'b0, 255, addr_pool[2]);
    write_prefix(2, 1'b1, 1'b1, 0, '1);
    write_prefix(3, 1'b1, 1'b0, 24, addr_pool[3]);
    send_frame(4'd0, 1'b1, ET_IPV4, 0, addr_pool[0], 34);
    send_frame(4'd15, 1'b0, ET_IPV4, 0, addr_pool[0] ^ 1, 34);
    send_frame(4'd7, 1'b1, ET_IPV6, 0, ~addr_pool[1], 54);
    write_prefix(2, 1'b0, 1'b1, 0, '0);
    send_frame(4'd7, 1'b1, ET_IPV6, 0, ~addr_pool[1], 54);
    send_frame(4'd7, 1'b0, ET_IPV6, 0, addr_pool[1], 60);
  endtask

  task automatic test_ethertypes();
    send_frame(4'd3, 1'b0, ET_ARP, 0, '0, 42);
    send_frame(4'd3, 1'b1, 16'h1234, 0, '0, 40);
    send_frame(4'd4, 1'b1, ET_IPV4, 1, addr_pool[0], 38);
    send_frame(4'd4, 1'b0, ET_IPV6, 2, addr_pool[1], 62);
    send_frame(4'd5, 1'b1, ET_ARP, 3, '0, 46);
  endtask

  task automatic test_short_headers();
    send_frame(4'd1, 1'b0, ET_ARP, 0, '0, 1);
    send_frame(4'd1, 1'b0, ET_ARP, 0, '0, 13);
    send_frame(4'd1, 1'b0, ET_ARP, 0, '0, 14);
    send_frame(4'd2, 1'b1, ET_ARP, 1, '0, 17);
    send_frame(4'd2, 1'b1, ET_IPV4, 0, addr_pool[0], 33);
    send_frame(4'd2, 1'b1, ET_IPV6, 0, addr_pool[1], 53);
  endtask

  task automatic test_midframe_write();
    send_frame(4'd9, 1'b0, ET_IPV4, 0, ~addr_pool[0], 40, 20);
    drain_results();
    write_prefix(5, 1'b0, 1'b0, 0, '0);
  endtask

  task automatic test_long_frame();
    send_frame(4'd6, 1'b1, ET_ARP, 0, '0, 65540);
    send_frame(4'd6, 1'b1, ET_ARP, 0, '0, 65535);
  endtask

  task automatic test_backpressure();
    hold_cycles <= 600;
    for (int i = 0; i < 6; i++) send_frame($urandom, $urandom, ET_ARP, 0, '0, 16);
  endtask

  task automatic test_random(int items);
    int sent, kind, tags, len;
    logic [15:0] et;
    logic [127:0] a;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        a = addr_pool[$urandom_range(3)];
        write_prefix($urandom_range(63), $urandom_range(99) < 80, $urandom,
                     $urandom_range(99) < 15 ? $urandom_range(255) : $urandom_range(128), a);
        sent++;
        continue;
      end
      tags = ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
      case ($urandom_range(9))
        0, 1, 2: et = ET_IPV4;
        3, 4, 5: et = ET_IPV6;
        6: et = ET_ARP;
        7: et = $urandom;
        default: et = ($urandom_range(1)) ? ET_VLAN : ET_QINQ;
      endcase
      a = addr_pool[$urandom_range(3)];
      if ($urandom_range(3) == 0) a = a ^ (128'd1 << $urandom_range(127));
      if ($urandom_range(3) == 0) a = {$urandom, $urandom, $urandom, $urandom};
      len = hdr_len(et, tags);
      len = ($urandom_range(9) == 0) ? $urandom_range(1, len) : len + $urandom_range(0, 16);
      send_frame($urandom, $urandom, et, tags, a, len);
      sent += len;
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_extremes();
    test_ethertypes();
    test_short_headers();
    test_midframe_write();
    test_long_frame();
    drain_results();
    snd_idle_pct = 24; rcv_idle_pct = 67;
    test_random(520);
    test_backpressure();
    snd_idle_pct = 67; rcv_idle_pct = 24;
    test_random(520);
    snd_idle_pct = 0; rcv_idle_pct = 0;
    test_random(520);
    in_if.valid <= 1'b0;
    drain_results();
    if (errors == 0) begin
      $display("PASS frame_scope_byte_counter");
    end else begin
      $display("FAIL frame_scope_byte_counter");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/fsbc_pkg.sv
sv/fsbc_if.sv
sv/fsbc_ctrl.sv
sv/fsbc_dp.sv
sv/frame_scope_byte_counter.sv
sv/fsbc_chk.sv
tb/sv/tb_top.sv
